// ===== rtl/pairwise_distance_range_search_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pairwise distance range search unit
// Small wrappers around concurrent assertions with clock and reset.
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_DISTANCE_RANGE_SEARCH_UNIT_MACROS_SVH
`define PAIRWISE_DISTANCE_RANGE_SEARCH_UNIT_MACROS_SVH

// same-cycle implication
`define PDRS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdrs assertion failed");

// next-cycle implication
`define PDRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdrs assertion failed");

`endif

// ===== rtl/pdrs_pkg.sv =====
// ----------------------------------------------------------------------------
// pdrs_pkg
// Shared widths, types and codes of the pairwise distance range search unit.
// ----------------------------------------------------------------------------
package pdrs_pkg;

    // field widths
    localparam int COORD_W    = 25;
    localparam int TAG_W      = 16;
    localparam int BOUND_W    = 17;
    localparam int DIST_W     = 49;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int BSQ_W      = 2 * BOUND_W;

    // table and pipeline
    localparam int DEPTH_DEF  = 64;
    localparam int PIPE_DEPTH = 4;

    // config port
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    // register reset values
    localparam logic [BOUND_W-1:0] CA_MIN_RST = 17'd3900;
    localparam logic [BOUND_W-1:0] CA_MAX_RST = 17'd8300;
    localparam logic [BOUND_W-1:0] CB_MIN_RST = 17'd2800;
    localparam logic [BOUND_W-1:0] CB_MAX_RST = 17'd4600;
    localparam logic               INC_PRO_RST = 1'b0;

    // op codes
    localparam logic OP_RESIDUE = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;

    typedef logic signed [COORD_W-1:0] t_coord;

    // one table entry / one query
    typedef struct packed {
        t_coord             ca_x;
        t_coord             ca_y;
        t_coord             ca_z;
        t_coord             cb_x;
        t_coord             cb_y;
        t_coord             cb_z;
        logic               pro;
        logic [TAG_W-1:0]   tag;
    } t_entry;

    // squared distance bounds
    typedef struct packed {
        logic [BSQ_W-1:0] ca_lo;
        logic [BSQ_W-1:0] ca_hi;
        logic [BSQ_W-1:0] cb_lo;
        logic [BSQ_W-1:0] cb_hi;
    } t_bounds;

    // distance pipeline result
    typedef struct packed {
        logic               vld;
        logic               match;
        logic [TAG_W-1:0]   tag;
        logic [DIST_W-1:0]  ca_sq;
        logic [DIST_W-1:0]  cb_sq;
    } t_dist_res;

    typedef enum logic [2:0] {
        REG_CA_MIN  = 3'd0,
        REG_CA_MAX  = 3'd1,
        REG_CB_MIN  = 3'd2,
        REG_CB_MAX  = 3'd3,
        REG_INC_PRO = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FLUSH
    } t_state;

endpackage

// ===== rtl/pdrs_cell.sv =====
// ----------------------------------------------------------------------------
// pdrs_cell
// One table slot of the residue ring. Loads a new entry or takes its
// neighbor's entry while the ring rotates.
// ----------------------------------------------------------------------------
module pdrs_cell (
    input  logic             i_clk,
    input  logic             i_shift,
    input  logic             i_load,
    input  pdrs_pkg::t_entry i_shift_data,
    input  pdrs_pkg::t_entry i_load_data,
    output pdrs_pkg::t_entry o_entry
);
    import pdrs_pkg::*;

    t_entry r_entry;

    // slot storage: append has priority, rotation otherwise
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= i_load_data;
        end else if (i_shift) begin
            r_entry <= i_shift_data;
        end
    end

    assign o_entry = r_entry;

endmodule

// ===== rtl/pdrs_dist.sv =====
// ----------------------------------------------------------------------------
// pdrs_dist
// Four-stage distance pipeline: absolute differences, squares, sums,
// range compare with output saturation.
// ----------------------------------------------------------------------------
module pdrs_dist (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  pdrs_pkg::t_entry    i_entry,
    input  pdrs_pkg::t_entry    i_query,
    input  pdrs_pkg::t_bounds   i_bounds,
    output pdrs_pkg::t_dist_res o_res
);
    import pdrs_pkg::*;

    localparam logic [SUM_W-1:0] DIST_MAX = SUM_W'({DIST_W{1'b1}});

    // |a - b|; range of the inputs keeps it within COORD_W bits
    function automatic logic [COORD_W-1:0] abs_diff(input t_coord a, input t_coord b);
        logic signed [COORD_W:0] d;
        d = (COORD_W+1)'(a) - (COORD_W+1)'(b);
        return d[COORD_W] ? COORD_W'(-d) : COORD_W'(d);
    endfunction

    logic [2:0][COORD_W-1:0] r_ca_abs, r_cb_abs;
    logic [2:0][SQ_W-1:0]    r_ca_sq, r_cb_sq;
    logic [SUM_W-1:0]        r_ca_sum, r_cb_sum;
    logic [TAG_W-1:0]        r_tag1, r_tag2, r_tag3, r_tag4;
    logic                    r_vld1, r_vld2, r_vld3, r_vld4;
    logic                    r_match;
    logic [DIST_W-1:0]       r_ca_out, r_cb_out;
    logic                    ca_ok, cb_ok;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
        end
    end

    // stage 1: absolute differences
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ca_abs[0] <= abs_diff(i_entry.ca_x, i_query.ca_x);
            r_ca_abs[1] <= abs_diff(i_entry.ca_y, i_query.ca_y);
            r_ca_abs[2] <= abs_diff(i_entry.ca_z, i_query.ca_z);
            r_cb_abs[0] <= abs_diff(i_entry.cb_x, i_query.cb_x);
            r_cb_abs[1] <= abs_diff(i_entry.cb_y, i_query.cb_y);
            r_cb_abs[2] <= abs_diff(i_entry.cb_z, i_query.cb_z);
            r_tag1      <= i_entry.tag;
        end
    end

    // stage 2: squares, one multiplier per axis and atom
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_ca_sq[j] <= SQ_W'(r_ca_abs[j]) * SQ_W'(r_ca_abs[j]);
                r_cb_sq[j] <= SQ_W'(r_cb_abs[j]) * SQ_W'(r_cb_abs[j]);
            end
            r_tag2 <= r_tag1;
        end
    end

    // stage 3: sums
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ca_sum <= SUM_W'(r_ca_sq[0]) + SUM_W'(r_ca_sq[1]) + SUM_W'(r_ca_sq[2]);
            r_cb_sum <= SUM_W'(r_cb_sq[0]) + SUM_W'(r_cb_sq[1]) + SUM_W'(r_cb_sq[2]);
            r_tag3   <= r_tag2;
        end
    end

    // stage 4: range check on exact sums, saturate for output
    assign ca_ok = (r_ca_sum >= SUM_W'(i_bounds.ca_lo))
                && (r_ca_sum <= SUM_W'(i_bounds.ca_hi));
    assign cb_ok = (r_cb_sum >= SUM_W'(i_bounds.cb_lo))
                && (r_cb_sum <= SUM_W'(i_bounds.cb_hi));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_match  <= ca_ok && cb_ok;
            r_tag4   <= r_tag3;
            r_ca_out <= (r_ca_sum > DIST_MAX) ? {DIST_W{1'b1}} : r_ca_sum[DIST_W-1:0];
            r_cb_out <= (r_cb_sum > DIST_MAX) ? {DIST_W{1'b1}} : r_cb_sum[DIST_W-1:0];
        end
    end

    assign o_res = '{vld: r_vld4, match: r_match, tag: r_tag4,
                     ca_sq: r_ca_out, cb_sq: r_cb_out};

endmodule

// ===== rtl/pairwise_distance_range_search_unit.sv =====
// ----------------------------------------------------------------------------
// pairwise_distance_range_search_unit
// Compares each complete residue with every stored residue and reports
// pairs whose squared CA and CB distances fall in the configured ranges.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake              | contents
//  ----------+-----------+------------------------+-----------------------------
//  input     | in        | i_in_valid/o_in_ready  | op, complete, CA/CB xyz, pro, tag
//  output    | out       | o_out_valid/i_out_ready| earlier/later tag, dist^2, last
//  config    | in        | APB psel/penable       | ca/cb min/max, include_prolines
//
//  A complete residue runs through scan, drain and flush: one rotation of the
//  residue ring past the distance pipeline (one slot per cycle when not
//  stalled), the pipeline drain, the append, and the return to idle.
//  Clear and incomplete residues leave the unit in idle.
//  A result waiting in the output register stalls the whole ring and pipeline.
//  Reset empties the table; table contents themselves are not cleared.
// ----------------------------------------------------------------------------
module pairwise_distance_range_search_unit #(
    parameter int TABLE_DEPTH = pdrs_pkg::DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input words
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_op,
    input  logic                               i_complete,
    input  logic signed [pdrs_pkg::COORD_W-1:0] i_ca_x,
    input  logic signed [pdrs_pkg::COORD_W-1:0] i_ca_y,
    input  logic signed [pdrs_pkg::COORD_W-1:0] i_ca_z,
    input  logic signed [pdrs_pkg::COORD_W-1:0] i_cb_x,
    input  logic signed [pdrs_pkg::COORD_W-1:0] i_cb_y,
    input  logic signed [pdrs_pkg::COORD_W-1:0] i_cb_z,
    input  logic                               i_is_proline,
    input  logic [pdrs_pkg::TAG_W-1:0]         i_residue_tag,
    // output words
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [pdrs_pkg::TAG_W-1:0]         o_earlier_tag,
    output logic [pdrs_pkg::TAG_W-1:0]         o_later_tag,
    output logic [pdrs_pkg::DIST_W-1:0]        o_ca_dist_sq,
    output logic [pdrs_pkg::DIST_W-1:0]        o_cb_dist_sq,
    output logic                               o_last,
    // config port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pdrs_pkg::ADDR_W-1:0]        paddr,
    input  logic [pdrs_pkg::DATA_W-1:0]        pwdata,
    output logic [pdrs_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);
    import pdrs_pkg::*;

    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int STEP_W  = $clog2(TABLE_DEPTH);
    localparam int FOUND_W = $clog2(TABLE_DEPTH);
    localparam int DRN_W   = $clog2(PIPE_DEPTH);
    localparam int MAX_RES = TABLE_DEPTH - 1;

    // ---------------- config registers ----------------
    logic [BOUND_W-1:0] r_ca_min, r_ca_max, r_cb_min, r_cb_max;
    logic               r_inc_pro;
    t_bounds            r_bnd;
    logic               cfg_wr;
    t_reg_idx           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ca_min  <= CA_MIN_RST;
            r_ca_max  <= CA_MAX_RST;
            r_cb_min  <= CB_MIN_RST;
            r_cb_max  <= CB_MAX_RST;
            r_inc_pro <= INC_PRO_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_CA_MIN:  r_ca_min  <= pwdata[BOUND_W-1:0];
                REG_CA_MAX:  r_ca_max  <= pwdata[BOUND_W-1:0];
                REG_CB_MIN:  r_cb_min  <= pwdata[BOUND_W-1:0];
                REG_CB_MAX:  r_cb_max  <= pwdata[BOUND_W-1:0];
                REG_INC_PRO: r_inc_pro <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register read mux
    always_comb begin
        unique case (cfg_idx)
            REG_CA_MIN:  prdata = DATA_W'(r_ca_min);
            REG_CA_MAX:  prdata = DATA_W'(r_ca_max);
            REG_CB_MIN:  prdata = DATA_W'(r_cb_min);
            REG_CB_MAX:  prdata = DATA_W'(r_cb_max);
            REG_INC_PRO: prdata = DATA_W'(r_inc_pro);
            default:     prdata = '0;
        endcase
    end

    // squared bounds, refreshed every cycle
    always_ff @(posedge i_clk) begin
        r_bnd.ca_lo <= BSQ_W'(r_ca_min) * BSQ_W'(r_ca_min);
        r_bnd.ca_hi <= BSQ_W'(r_ca_max) * BSQ_W'(r_ca_max);
        r_bnd.cb_lo <= BSQ_W'(r_cb_min) * BSQ_W'(r_cb_min);
        r_bnd.cb_hi <= BSQ_W'(r_cb_max) * BSQ_W'(r_cb_max);
    end

    // ---------------- control ----------------
    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step;
    logic [DRN_W-1:0]    r_drain;
    logic [CNT_W-1:0]    r_cnt;
    logic [FOUND_W-1:0]  r_found;
    t_entry              r_q;

    logic adv, in_acc, start, last_step, drain_last;
    logic scan_issue, drain_step, flush_do;
    logic capture, emit_mid, emit_end, dist_vld;

    t_entry    w_q [TABLE_DEPTH];
    t_dist_res w_res;

    // the whole datapath moves only when the output register can take a word
    assign adv        = !o_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;
    assign start      = in_acc && (i_op == OP_RESIDUE) && i_complete;
    assign last_step  = (r_step == STEP_W'(TABLE_DEPTH - 1));
    assign drain_last = (r_drain == DRN_W'(PIPE_DEPTH - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (start) n_state = ST_SCAN;
            ST_SCAN:  if (adv && last_step) n_state = ST_DRAIN;
            ST_DRAIN: if (adv && drain_last) n_state = ST_FLUSH;
            ST_FLUSH: if (adv) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        scan_issue = 1'b0;
        drain_step = 1'b0;
        flush_do   = 1'b0;
        unique case (r_state)
            ST_IDLE:  o_in_ready = 1'b1;
            ST_SCAN:  scan_issue = adv;
            ST_DRAIN: drain_step = adv;
            ST_FLUSH: flush_do   = adv;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ring position and drain counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_drain <= '0;
        end else begin
            if (start) begin
                r_step <= '0;
            end else if (scan_issue) begin
                r_step <= r_step + STEP_W'(1);
            end
            if (scan_issue && last_step) begin
                r_drain <= '0;
            end else if (drain_step) begin
                r_drain <= r_drain + DRN_W'(1);
            end
        end
    end

    // stored count: cleared by op, bumped on append until full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_acc && (i_op == OP_CLEAR)) begin
            r_cnt <= '0;
        end else if (flush_do && (r_cnt != CNT_W'(TABLE_DEPTH))) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    // query latch
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_q.ca_x <= i_ca_x;
            r_q.ca_y <= i_ca_y;
            r_q.ca_z <= i_ca_z;
            r_q.cb_x <= i_cb_x;
            r_q.cb_y <= i_cb_y;
            r_q.cb_z <= i_cb_z;
            r_q.pro  <= i_is_proline;
            r_q.tag  <= i_residue_tag;
        end
    end

    // ---------------- residue ring ----------------
    // slot 0 feeds the pipeline; a full turn brings every entry home
    for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
        pdrs_cell u_cell (
            .i_clk        (i_clk),
            .i_shift      (scan_issue),
            .i_load       (flush_do && (r_cnt == CNT_W'(gi))),
            .i_shift_data (w_q[(gi + 1) % TABLE_DEPTH]),
            .i_load_data  (r_q),
            .o_entry      (w_q[gi])
        );
    end

    // only filled slots, and proline pairs only when allowed
    assign dist_vld = scan_issue && (CNT_W'(r_step) < r_cnt)
                   && (r_inc_pro || !(r_q.pro || w_q[0].pro));

    pdrs_dist u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_vld    (dist_vld),
        .i_entry  (w_q[0]),
        .i_query  (r_q),
        .i_bounds (r_bnd),
        .o_res    (w_res)
    );

    // ---------------- result hold and output ----------------
    // one match is held back so the final one can carry last
    logic                r_hold_vld;
    logic [TAG_W-1:0]    r_hold_tag;
    logic [DIST_W-1:0]   r_hold_ca, r_hold_cb;
    logic                r_out_vld;
    logic [TAG_W-1:0]    r_out_etag, r_out_ltag;
    logic [DIST_W-1:0]   r_out_ca, r_out_cb;
    logic                r_out_last;

    assign capture  = adv && w_res.vld && w_res.match && (r_found != FOUND_W'(MAX_RES));
    assign emit_mid = capture && r_hold_vld;
    assign emit_end = flush_do && r_hold_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found    <= '0;
            r_hold_vld <= 1'b0;
        end else begin
            if (start) begin
                r_found <= '0;
            end else if (capture) begin
                r_found <= r_found + FOUND_W'(1);
            end
            if (capture) begin
                r_hold_vld <= 1'b1;
            end else if (flush_do) begin
                r_hold_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (capture) begin
            r_hold_tag <= w_res.tag;
            r_hold_ca  <= w_res.ca_sq;
            r_hold_cb  <= w_res.cb_sq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit_mid || emit_end) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_mid || emit_end) begin
            r_out_etag <= r_hold_tag;
            r_out_ltag <= r_q.tag;
            r_out_ca   <= r_hold_ca;
            r_out_cb   <= r_hold_cb;
            r_out_last <= emit_end;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_earlier_tag = r_out_etag;
    assign o_later_tag   = r_out_ltag;
    assign o_ca_dist_sq  = r_out_ca;
    assign o_cb_dist_sq  = r_out_cb;
    assign o_last        = r_out_last;

endmodule

// ===== rtl/pdrs_checker.sv =====
// ----------------------------------------------------------------------------
// pdrs_checker
// Port-level checks on the pairwise distance range search unit.
// ----------------------------------------------------------------------------
`include "pairwise_distance_range_search_unit_macros.svh"

module pdrs_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic                               i_op,
    input logic                               i_complete,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic [pdrs_pkg::TAG_W-1:0]         o_earlier_tag,
    input logic [pdrs_pkg::TAG_W-1:0]         o_later_tag,
    input logic [pdrs_pkg::DIST_W-1:0]        o_ca_dist_sq,
    input logic [pdrs_pkg::DIST_W-1:0]        o_cb_dist_sq,
    input logic                               o_last
);
    import pdrs_pkg::*;

    logic                        in_acc, acc_clear, acc_skip, acc_start, out_stall;
    logic [2*TAG_W+2*DIST_W:0]   out_word;

    assign in_acc    = i_in_valid && o_in_ready;
    assign acc_clear = in_acc && (i_op == OP_CLEAR);
    assign acc_skip  = in_acc && (i_op == OP_RESIDUE) && !i_complete;
    assign acc_start = in_acc && (i_op == OP_RESIDUE) && i_complete;
    assign out_stall = o_out_valid && !i_out_ready;
    assign out_word  = {o_earlier_tag, o_later_tag, o_ca_dist_sq, o_cb_dist_sq, o_last};

    // clear and incomplete residues leave the unit ready in the next cycle
    `PDRS_ASSERT_NEXT(a_clear_one_cycle, i_clk, i_rst_n, acc_clear, o_in_ready)
    `PDRS_ASSERT_NEXT(a_skip_incomplete, i_clk, i_rst_n, acc_skip, o_in_ready)

    // a complete residue starts a scan
    `PDRS_ASSERT_NEXT(a_scan_busy, i_clk, i_rst_n, acc_start, !o_in_ready)

    // a word that is not the last of its residue means a scan is still running
    `PDRS_ASSERT_IMPLY(a_mid_word_busy, i_clk, i_rst_n, o_out_valid && !o_last, !o_in_ready)

    // stalled output word holds
    `PDRS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(out_word))

endmodule

bind pairwise_distance_range_search_unit pdrs_checker u_pdrs_checker (.*);
